// File: rtl/core/virtual_texture_page_cache_macros.svh
// Assertion macros shared by the page cache checker.
`ifndef VIRTUAL_TEXTURE_PAGE_CACHE_MACROS_SVH
`define VIRTUAL_TEXTURE_PAGE_CACHE_MACROS_SVH

// Consequent must hold in the clock after the antecedent.
`define VTPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page cache: next-cycle check failed");

// Consequent must hold in the same clock as the antecedent.
`define VTPC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("page cache: same-cycle check failed");

`endif

// File: rtl/core/vtpc_pkg.sv
// Shared types and constants of the virtual texture page cache.
package vtpc_pkg;

	localparam int NOW_W = 48;
	localparam int KEY_W = 64;
	localparam int SRC_IN_W = 10;
	localparam int LIFE_W = 32;
	localparam int SLOT_OUT_W = 8;
	localparam int COORD_W = 4;

	localparam int GRID_SIDE_DEF = 16;
	localparam int SOURCE_BITS_DEF = 10;
	localparam logic [LIFE_W-1:0] LIFETIME_RESET = 32'd10;

	typedef enum logic [1:0] {
		ST_IGNORED = 2'd0,
		ST_HIT     = 2'd1,
		ST_ALLOC   = 2'd2,
		ST_FULL    = 2'd3
	} vtpc_status_t;

	typedef struct packed {
		logic [NOW_W-1:0]    now;
		logic [KEY_W-1:0]    page_key;
		logic [SRC_IN_W-1:0] source;
	} vtpc_req_t;

	typedef struct packed {
		vtpc_status_t          status;
		logic [SLOT_OUT_W-1:0] slot;
		logic [COORD_W-1:0]    upload_x;
		logic [COORD_W-1:0]    upload_y;
		logic                  evicted;
		logic [SRC_IN_W-1:0]   evicted_source;
		logic [KEY_W-1:0]      evicted_key;
	} vtpc_rsp_t;

	typedef struct packed {
		logic         capture;
		logic         scan;
		logic         resp;
		vtpc_status_t resp_code;
	} vtpc_cmd_t;

	typedef struct packed {
		logic src_zero;
		logic hit;
		logic scan_end;
		logic alloc_ok;
	} vtpc_stat_t;

endpackage

// File: rtl/core/virtual_texture_page_cache.sv
// Top level of the virtual texture page cache.
// An ignored request (source zero) gives its result beat in the cycle after acceptance.
// Other requests scan the resident slots through the single slot-memory read port,
// one slot per cycle, and a hit ends the scan early; one request is in work at a time.
// Reset empties the cache and restores the lifetime; no clearing pass is needed.
module virtual_texture_page_cache import vtpc_pkg::*; #(
	parameter int GRID_SIDE = GRID_SIDE_DEF,
	parameter int SOURCE_BITS = SOURCE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  vtpc_req_t         req,
	output logic              done,
	output vtpc_rsp_t         rsp,
	input  logic              cfg_wr_en,
	input  logic [LIFE_W-1:0] cfg_wr_data
);

	vtpc_cmd_t  cmd;
	vtpc_stat_t st;

	vtpc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	vtpc_datapath #(
		.GRID_SIDE   (GRID_SIDE),
		.SOURCE_BITS (SOURCE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.st          (st),
		.rsp         (rsp)
	);

endmodule

// File: rtl/core/vtpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vtpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/vtpc_ctrl.sv
// Controller state machine of the page cache: accept, scan and respond.
module vtpc_ctrl import vtpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  vtpc_stat_t st,
	output vtpc_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		cmd = '0;
		cmd.resp_code = ST_IGNORED;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (st.src_zero) begin
						cmd.resp = 1'b1;
						cmd.resp_code = ST_IGNORED;
					end else begin
						cmd.capture = 1'b1;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.hit) begin
					cmd.resp = 1'b1;
					cmd.resp_code = ST_HIT;
				end else if (st.scan_end) begin
					cmd.resp = 1'b1;
					cmd.resp_code = st.alloc_ok ? ST_ALLOC : ST_FULL;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.resp;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_SCAN;
						busy_q <= 1'b1;
					end
				end
				S_SCAN: begin
					if (cmd.resp) begin
						state_q <= S_IDLE;
						busy_q <= 1'b0;
					end
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// File: rtl/core/vtpc_datapath.sv
// Datapath of the page cache: request registers, slot memory scan and result register.
module vtpc_datapath import vtpc_pkg::*; #(
	parameter int GRID_SIDE = GRID_SIDE_DEF,
	parameter int SOURCE_BITS = SOURCE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vtpc_req_t         req,
	input  logic              cfg_wr_en,
	input  logic [LIFE_W-1:0] cfg_wr_data,
	input  vtpc_cmd_t         cmd,
	output vtpc_stat_t        st,
	output vtpc_rsp_t         rsp
);

	localparam int SLOT_COUNT = GRID_SIDE * GRID_SIDE;
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int COL_W = $clog2(GRID_SIDE);
	localparam int SRC_W = (SOURCE_BITS < SRC_IN_W) ? SOURCE_BITS : SRC_IN_W;
	localparam int ENTRY_W = KEY_W + NOW_W + SRC_W;

	logic [LIFE_W-1:0] lifetime_q;
	logic [SLOT_W-1:0] fill_q;

	logic [NOW_W-1:0] now_q;
	logic [KEY_W-1:0] key_q;
	logic [SRC_W-1:0] src_q;
	logic [NOW_W-1:0] exp_q;

	logic [CNT_W-1:0] rd_idx_q;
	logic [COL_W-1:0] rd_col_q;
	logic [COL_W-1:0] rd_row_q;

	logic              cmp_vld_s1;
	logic [SLOT_W-1:0] cmp_idx_s1;

	logic              free_found_q;
	logic [SLOT_W-1:0] free_idx_q;
	logic [COL_W-1:0]  free_col_q;
	logic [COL_W-1:0]  free_row_q;
	logic [KEY_W-1:0]  ev_key_q;
	logic [SRC_W-1:0]  ev_src_q;

	vtpc_rsp_t rsp_q;
	vtpc_rsp_t rsp_d;

	logic [SRC_W-1:0]   src_in;
	logic [NOW_W:0]     exp_sum;
	logic [NOW_W-1:0]   exp_in;
	logic               rd_more;
	logic               issue;
	logic [ENTRY_W-1:0] rd_data;
	logic [KEY_W-1:0]   ent_key;
	logic [NOW_W-1:0]   ent_exp;
	logic [SRC_W-1:0]   ent_src;
	logic               hit;
	logic               expired;
	logic               wr_en;
	logic [SLOT_W-1:0]  wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic [SLOT_W-1:0]  alloc_idx;
	logic [COL_W-1:0]   alloc_col;
	logic [COL_W-1:0]   alloc_row;

	logic [SLOT_W+SLOT_OUT_W-1:0] hit_slot_ext;
	logic [SLOT_W+SLOT_OUT_W-1:0] alloc_slot_ext;
	logic [COL_W+COORD_W-1:0]     alloc_x_ext;
	logic [COL_W+COORD_W-1:0]     alloc_y_ext;
	logic [SRC_W+SRC_IN_W-1:0]    ev_src_ext;

	assign src_in = req.source[SRC_W-1:0];
	assign exp_sum = {1'b0, req.now} + {{(NOW_W + 1 - LIFE_W){1'b0}}, lifetime_q};
	assign exp_in = exp_sum[NOW_W] ? {NOW_W{1'b1}} : exp_sum[NOW_W-1:0];

	assign rd_more = rd_idx_q <= CNT_W'(fill_q);
	assign issue = cmd.scan && rd_more;

	assign ent_key = rd_data[ENTRY_W-1 -: KEY_W];
	assign ent_exp = rd_data[SRC_W +: NOW_W];
	assign ent_src = rd_data[SRC_W-1:0];

	assign hit = cmp_vld_s1 && (ent_key == key_q);
	assign expired = cmp_vld_s1 && (now_q >= ent_exp);

	assign st.src_zero = (src_in == '0);
	assign st.hit = hit;
	assign st.scan_end = !cmp_vld_s1 && !rd_more;
	assign st.alloc_ok = free_found_q || (fill_q != SLOT_W'(SLOT_COUNT - 1));

	assign alloc_idx = free_found_q ? free_idx_q : rd_idx_q[SLOT_W-1:0];
	assign alloc_col = free_found_q ? free_col_q : rd_col_q;
	assign alloc_row = free_found_q ? free_row_q : rd_row_q;

	assign hit_slot_ext = {{SLOT_OUT_W{1'b0}}, cmp_idx_s1};
	assign alloc_slot_ext = {{SLOT_OUT_W{1'b0}}, alloc_idx};
	assign alloc_x_ext = {{COORD_W{1'b0}}, alloc_col};
	assign alloc_y_ext = {{COORD_W{1'b0}}, alloc_row};
	assign ev_src_ext = {{SRC_IN_W{1'b0}}, ev_src_q};

	assign wr_en = cmd.resp && (cmd.resp_code == ST_HIT || cmd.resp_code == ST_ALLOC);
	assign wr_addr = (cmd.resp_code == ST_HIT) ? cmp_idx_s1 : alloc_idx;
	assign wr_data = {key_q, exp_q, (cmd.resp_code == ST_HIT) ? ent_src : src_q};

	vtpc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (rd_idx_q[SLOT_W-1:0]),
		.rd_data (rd_data)
	);

	always_comb begin
		rsp_d = '0;
		rsp_d.status = cmd.resp_code;
		unique case (cmd.resp_code)
			ST_HIT: begin
				rsp_d.slot = hit_slot_ext[SLOT_OUT_W-1:0];
			end
			ST_ALLOC: begin
				rsp_d.slot = alloc_slot_ext[SLOT_OUT_W-1:0];
				rsp_d.upload_x = alloc_x_ext[COORD_W-1:0];
				rsp_d.upload_y = alloc_y_ext[COORD_W-1:0];
				if (free_found_q) begin
					rsp_d.evicted = 1'b1;
					rsp_d.evicted_source = ev_src_ext[SRC_IN_W-1:0];
					rsp_d.evicted_key = ev_key_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= LIFETIME_RESET;
			fill_q <= '0;
			cmp_vld_s1 <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				lifetime_q <= cfg_wr_data;
			end
			if (cmd.resp && cmd.resp_code == ST_ALLOC && !free_found_q) begin
				fill_q <= fill_q + SLOT_W'(1);
			end
			cmp_vld_s1 <= issue;
			if (cmd.capture) begin
				free_found_q <= 1'b0;
			end else if (expired) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q <= req.now;
			key_q <= req.page_key;
			src_q <= src_in - SRC_W'(1);
			exp_q <= exp_in;
			rd_idx_q <= CNT_W'(1);
			rd_col_q <= COL_W'(1);
			rd_row_q <= '0;
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + CNT_W'(1);
			if (rd_col_q == COL_W'(GRID_SIDE - 1)) begin
				rd_col_q <= '0;
				rd_row_q <= rd_row_q + COL_W'(1);
			end else begin
				rd_col_q <= rd_col_q + COL_W'(1);
			end
		end
		if (issue) begin
			cmp_idx_s1 <= rd_idx_q[SLOT_W-1:0];
		end
		if (expired && !free_found_q) begin
			free_idx_q <= cmp_idx_s1;
			free_col_q <= rd_col_q == '0 ? COL_W'(GRID_SIDE - 1) : rd_col_q - COL_W'(1);
			free_row_q <= rd_col_q == '0 ? rd_row_q - COL_W'(1) : rd_row_q;
			ev_key_q <= ent_key;
			ev_src_q <= ent_src;
		end
		if (cmd.resp) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

// File: rtl/core/vtpc_checker.sv
// Port-level checker of the page cache and its bind to the top level.
`include "virtual_texture_page_cache_macros.svh"

module vtpc_checker import vtpc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input vtpc_req_t         req,
	input logic              done,
	input vtpc_rsp_t         rsp
);

	// A request with no material source is answered as ignored without a scan.
	`VTPC_ASSERT_NEXT(a_ignore_next, start && !busy && req.source == '0, done && rsp.status == ST_IGNORED)

	// A request with an odd source (bit 0 set) makes the block busy for its scan.
	`VTPC_ASSERT_NEXT(a_scan_busy, start && !busy && req.source[0], busy)

	// Only an allocation can report a displaced page.
	`VTPC_ASSERT_SAME(a_evict_alloc, done && rsp.status != ST_ALLOC, !rsp.evicted && rsp.evicted_key == '0)

	// Ignored and refused requests carry no slot or grid position.
	`VTPC_ASSERT_SAME(a_empty_fields, done && (rsp.status == ST_IGNORED || rsp.status == ST_FULL), rsp.slot == '0 && rsp.upload_x == '0 && rsp.upload_y == '0)

endmodule

bind virtual_texture_page_cache vtpc_checker u_vtpc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.req         (req),
	.done        (done),
	.rsp         (rsp)
);

// File: tb/virtual_texture_page_cache_checker.sv
`timescale 1ns / 100ps
// Checker for the page cache: predicts every result beat and compares it field by field.
module virtual_texture_page_cache_checker import vtpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  vtpc_req_t         req,
	input  logic              done,
	input  vtpc_rsp_t         rsp,
	input  logic              cfg_wr_en,
	input  logic [LIFE_W-1:0] cfg_wr_data,
	output int                fail_count,
	output int                pending
);
	localparam int SLOTS = GRID_SIDE_DEF * GRID_SIDE_DEF;
	localparam int PRINT_CAP = 60;
	localparam logic [NOW_W-1:0] TIME_MAX = '1;

	logic                resident [SLOTS];
	logic [KEY_W-1:0]    page_tag [SLOTS];
	logic [NOW_W-1:0]    page_expiry [SLOTS];
	logic [SRC_IN_W-1:0] page_material [SLOTS];
	logic [LIFE_W-1:0]   lifetime;
	vtpc_rsp_t           page_results_q [$];

	function automatic vtpc_rsp_t lookup_page(vtpc_req_t r);
		vtpc_rsp_t res;
		logic [SOURCE_BITS_DEF-1:0] src;
		logic [NOW_W:0] life_ext;
		logic [NOW_W:0] sum;
		logic [NOW_W-1:0] expiry;
		bit found;
		res = '0;
		found = 1'b0;
		src = r.source[SOURCE_BITS_DEF-1:0];
		life_ext = {{(NOW_W + 1 - LIFE_W){1'b0}}, lifetime};
		sum = {1'b0, r.now} + life_ext;
		expiry = sum[NOW_W] ? TIME_MAX : sum[NOW_W-1:0];
		if (src != '0) begin
			for (int i = 1; i < SLOTS; i++) begin
				if (!found && resident[i] && page_tag[i] == r.page_key) begin
					found = 1'b1;
					page_expiry[i] = expiry;
					res.status = ST_HIT;
					res.slot = SLOT_OUT_W'(i);
				end
			end
			for (int i = 1; i < SLOTS; i++) begin
				if (!found && (!resident[i] || r.now >= page_expiry[i])) begin
					found = 1'b1;
					if (resident[i]) begin
						res.evicted = 1'b1;
						res.evicted_source = page_material[i];
						res.evicted_key = page_tag[i];
					end
					resident[i] = 1'b1;
					page_tag[i] = r.page_key;
					page_expiry[i] = expiry;
					page_material[i] = SRC_IN_W'(src - SOURCE_BITS_DEF'(1));
					res.status = ST_ALLOC;
					res.slot = SLOT_OUT_W'(i);
					res.upload_x = COORD_W'(i % GRID_SIDE_DEF);
					res.upload_y = COORD_W'(i / GRID_SIDE_DEF);
				end
			end
			if (!found) begin
				res.status = ST_FULL;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
			input logic [KEY_W-1:0] want);
		if (fail_count < PRINT_CAP) begin
			$display("page cache: %s mismatch, got %0h expected %0h at %0t", what, got, want,
				$realtime);
		end
		fail_count++;
	endtask

	task automatic check_result(input vtpc_rsp_t got, input vtpc_rsp_t want);
		if (got.status !== want.status) begin
			report_mismatch("status", KEY_W'(got.status), KEY_W'(want.status));
		end
		if (got.slot !== want.slot) begin
			report_mismatch("slot", KEY_W'(got.slot), KEY_W'(want.slot));
		end
		if (got.upload_x !== want.upload_x) begin
			report_mismatch("upload_x", KEY_W'(got.upload_x), KEY_W'(want.upload_x));
		end
		if (got.upload_y !== want.upload_y) begin
			report_mismatch("upload_y", KEY_W'(got.upload_y), KEY_W'(want.upload_y));
		end
		if (got.evicted !== want.evicted) begin
			report_mismatch("evicted", KEY_W'(got.evicted), KEY_W'(want.evicted));
		end
		if (got.evicted_source !== want.evicted_source) begin
			report_mismatch("evicted_source", KEY_W'(got.evicted_source),
				KEY_W'(want.evicted_source));
		end
		if (got.evicted_key !== want.evicted_key) begin
			report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				resident[i] = 1'b0;
			end
			lifetime = LIFETIME_RESET;
			page_results_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en) begin
				lifetime = cfg_wr_data;
			end
			if ($isunknown(done)) begin
				report_mismatch("done strobe", KEY_W'(done), '0);
			end else if (done) begin
				if (page_results_q.size() == 0) begin
					report_mismatch("unexpected beat", KEY_W'(rsp.status), '0);
				end else begin
					check_result(rsp, page_results_q.pop_front());
				end
			end
			if (start && !busy) begin
				page_results_q.push_back(lookup_page(req));
			end
			pending = page_results_q.size();
		end
	end

endmodule

// File: tb/virtual_texture_page_cache_tb.sv
`timescale 1ns / 100ps
// Testbench top for the page cache: clock, reset, request stimulus, lifetime phases and verdict.
module virtual_texture_page_cache_tb;
	import vtpc_pkg::*;

	localparam int ITEM_TARGET = 1170;
	localparam int FINAL_ITEMS = 40;
	localparam int FILL_ITEMS = 270;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 300;
	localparam logic [NOW_W-1:0] TIME_MAX = '1;
	localparam logic [LIFE_W-1:0] LIFE_MAX = '1;
	localparam logic [NOW_W:0] BIG_JUMP = 49'h2_0000_0000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	vtpc_req_t           req = '0;
	logic                done;
	vtpc_rsp_t           rsp;
	logic                cfg_wr_en = 1'b0;
	logic [LIFE_W-1:0]   cfg_wr_data = '0;
	int                  fail_count;
	int                  pending;
	int                  cycle_count = 0;
	int                  page_requests = 0;
	logic [NOW_W-1:0]    clock_ticks;
	logic [KEY_W-1:0]    key_pool [40];

	always #6 clk = ~clk;

	virtual_texture_page_cache dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	virtual_texture_page_cache_checker page_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [KEY_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 19);
		if (quiet || r < 12) begin
			return 0;
		end
		if (r < 18) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 60);
	endfunction

	function automatic logic [NOW_W-1:0] later(logic [NOW_W-1:0] t, logic [NOW_W:0] advance);
		logic [NOW_W+1:0] s;
		s = {2'b00, t} + {1'b0, advance};
		return (s > {2'b00, TIME_MAX}) ? TIME_MAX : s[NOW_W-1:0];
	endfunction

	task automatic send_page(input logic [NOW_W-1:0] t, input logic [KEY_W-1:0] key,
			input logic [SRC_IN_W-1:0] src, input int gap);
		vtpc_req_t r;
		r.now = t;
		r.page_key = key;
		r.source = src;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		if (src != '0) begin
			page_requests++;
		end
	endtask

	task automatic set_lifetime(input logic [LIFE_W-1:0] v);
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int episode;
		int n_items;
		int pool_n;
		int kind;
		bit quiet;
		logic [LIFE_W-1:0] life;
		logic [NOW_W:0] advance;
		logic [NOW_W-1:0] t;
		logic [KEY_W-1:0] key;
		logic [SRC_IN_W-1:0] src;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_page(48'd0, rand64(), 10'd0, pick_gap(1'b0));
		send_page(TIME_MAX, '1, 10'd0, pick_gap(1'b0));
		send_page(48'd0, 64'd1, 10'd1, pick_gap(1'b0));
		send_page(48'd5, 64'd1, 10'd1, pick_gap(1'b0));
		send_page(48'd100, 64'd1, 10'd7, pick_gap(1'b0));
		send_page(48'd100, '1, 10'd1023, pick_gap(1'b0));
		send_page(48'd101, 64'd0, 10'd1, pick_gap(1'b0));
		send_page(48'd102, 64'd0, 10'd2, pick_gap(1'b0));
		send_page(48'd112, 64'd5, 10'd3, pick_gap(1'b0));
		send_page(48'd112, 64'd6, 10'd3, pick_gap(1'b0));
		send_page(TIME_MAX - 48'd3, 64'd7, 10'd4, pick_gap(1'b0));
		send_page(TIME_MAX - 48'd1, 64'd8, 10'd5, pick_gap(1'b0));
		send_page(TIME_MAX, 64'd9, 10'd6, pick_gap(1'b0));
		send_page(TIME_MAX, 64'd10, 10'd6, pick_gap(1'b0));
		set_lifetime('0);
		send_page(48'd1000, 64'd11, 10'd1, pick_gap(1'b0));
		send_page(48'd1000, 64'd12, 10'd512, pick_gap(1'b0));
		send_page(48'd1000, 64'd12, 10'd512, pick_gap(1'b0));
		set_lifetime(LIFE_MAX);
		send_page(48'd2000, 64'd13, 10'd9, pick_gap(1'b0));
		send_page(48'd2001, 64'd14, 10'd1023, pick_gap(1'b0));

		clock_ticks = 48'd2001;
		episode = 0;
		while (page_requests < ITEM_TARGET - FINAL_ITEMS) begin
			case ((episode < 3) ? episode : $urandom_range(3, 8))
				0: life = LIFE_MAX;
				1: life = '0;
				2: life = 32'd1;
				3: life = $urandom_range(2, 64);
				4: life = $urandom;
				5: life = LIFE_MAX;
				6: life = $urandom_range(65, 5000);
				7: life = LIFETIME_RESET;
				default: life = '0;
			endcase
			set_lifetime(life);
			if (episode == 1 || $urandom_range(0, 2) != 0) begin
				advance = BIG_JUMP + ({17'd0, $urandom} << $urandom_range(0, 3));
			end else begin
				advance = (NOW_W + 1)'($urandom_range(0, 100));
			end
			clock_ticks = later(clock_ticks, advance);

			if (episode == 0) begin
				for (int k = 0; k < FILL_ITEMS; k++) begin
					clock_ticks = later(clock_ticks, (NOW_W + 1)'(1));
					send_page(clock_ticks, rand64(), SRC_IN_W'($urandom_range(1, 1023)),
						pick_gap(k < 100));
				end
			end else begin
				quiet = ($urandom_range(0, 3) == 0);
				pool_n = $urandom_range(2, 40);
				for (int k = 0; k < pool_n; k++) begin
					key_pool[k] = rand64();
				end
				if ($urandom_range(0, 3) == 0) begin
					key_pool[0] = '0;
				end
				if ($urandom_range(0, 3) == 0) begin
					key_pool[pool_n - 1] = '1;
				end
				n_items = $urandom_range(20, 80);
				for (int k = 0; k < n_items; k++) begin
					kind = $urandom_range(0, 31);
					if (life <= 64) begin
						advance = (NOW_W + 1)'($urandom_range(0, 2 * life + 2));
					end else if ($urandom_range(0, 9) == 0) begin
						advance = (NOW_W + 1)'(life) + (NOW_W + 1)'($urandom_range(0, 3));
					end else begin
						advance = (NOW_W + 1)'($urandom_range(0, 16));
					end
					clock_ticks = later(clock_ticks, advance);
					t = (kind == 2) ? NOW_W'(rand64()) : clock_ticks;
					key = (kind >= 3 && kind <= 5) ? rand64() :
						key_pool[$urandom_range(0, pool_n - 1)];
					src = (kind < 2) ? '0 : SRC_IN_W'($urandom_range(1, 1023));
					send_page(t, key, src, pick_gap(quiet));
				end
			end
			episode++;
		end

		set_lifetime(LIFE_MAX);
		clock_ticks = TIME_MAX - NOW_W'($urandom_range(0, 2000));
		for (int k = 0; k < FINAL_ITEMS; k++) begin
			clock_ticks = later(clock_ticks, (NOW_W + 1)'($urandom_range(0, 100)));
			key = ($urandom_range(0, 2) == 0) ? rand64() : key_pool[$urandom_range(0, 1)];
			send_page(clock_ticks, key, SRC_IN_W'($urandom_range(1, 1023)), pick_gap(1'b0));
		end

		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/vtpc_pkg.sv
rtl/core/vtpc_ram.sv
rtl/core/vtpc_ctrl.sv
rtl/core/vtpc_datapath.sv
rtl/core/virtual_texture_page_cache.sv
rtl/core/vtpc_checker.sv
tb/virtual_texture_page_cache_checker.sv
tb/virtual_texture_page_cache_tb.sv
